/* design/smn_pkg.sv */
// Shared types and constants for the symmetric matrix norm unit.
// No dependencies.
package smn_pkg;
	localparam logic [1:0] KIND_MAXABS = 2'd0;
	localparam logic [1:0] KIND_ONEINF = 2'd1;
	localparam logic [1:0] KIND_FROB   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] REG_KIND    = 2'd0;
	localparam logic [1:0] REG_TRI     = 2'd1;
	localparam logic [1:0] REG_ORDER   = 2'd2;
	localparam int unsigned SUM_W = 30;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// queued work item between front and back
	typedef struct packed {
		logic       take;
		logic       last;
		logic       diag;
		logic [5:0] row;
		logic [5:0] col;
		logic [23:0] mag;
		logic [1:0] kind;
	} smn_op_t;
endpackage

/* design/symmetric_matrix_norm_unit.sv */
// Symmetric matrix norm unit: front filter, two-entry queue, row-sum back end.
// Per item the back end steps through IDLE, RD and SQRT; one-norm items add WR,
// and off-diagonal ones RD2 and WR2 (read/write of two rows on one RAM port); the
// queue registers items between front and back. Last item in Frobenius mode adds
// a bit-serial square root. After each result and after reset a clearing pass
// sweeps all MAX_ORDER RAM entries.
// arst_n clears control state registers to their reset values.
module symmetric_matrix_norm_unit import smn_pkg::*; #(
	parameter int MAX_ORDER   = 64,
	parameter int VALUE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // row_index[5:0], col_index[11:6], element_value[35:12], pad
	input  logic        s_tlast,  // last_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // norm_value[29:0], pad
);
	logic [1:0] kind_q;
	logic       tri_q;
	logic [6:0] order_q;
	logic       q_valid, q_ready;
	smn_op_t    q_op;
	logic [SUM_W-1:0] norm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_MAXABS;
			tri_q   <= 1'b0;
			order_q <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KIND:  kind_q  <= cfg_data[1:0];
				REG_TRI:   tri_q   <= cfg_data[0];
				REG_ORDER: order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	smn_front #(.MAX_ORDER(MAX_ORDER), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n, .norm_kind(kind_q), .triangle(tri_q), .order(order_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.row(s_tdata[5:0]), .col(s_tdata[11:6]), .value(s_tdata[35:12]),
		.last(s_tlast), .q_valid, .q_ready, .q_op
	);

	smn_back #(.MAX_ORDER(MAX_ORDER)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_op,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_norm(norm)
	);

	assign m_tdata = {2'b00, norm};
endmodule

/* design/smn_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module smn_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* design/smn_front.sv */
// Front end: takes elements, filters by triangle/order, forms magnitude.
// Depends on smn_pkg.
module smn_front import smn_pkg::*; #(
	parameter int MAX_ORDER   = 64,
	parameter int VALUE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  norm_kind,
	input  logic        triangle,
	input  logic [6:0]  order,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic [23:0] value,
	input  logic        last,
	output logic        q_valid,
	input  logic        q_ready,
	output smn_op_t     q_op
);
	localparam int QD = 2;
	smn_op_t     fifo_q [QD];
	logic [1:0]  cnt_q;
	logic        rp_q, wp_q;
	logic [6:0]  eff;
	logic [VALUE_WIDTH-1:0] raw, neg;
	smn_op_t     op;
	logic        push, pop;

	always_comb begin
		eff = (order > 7'(MAX_ORDER)) ? 7'(MAX_ORDER) : order;
		raw = value[VALUE_WIDTH-1:0];
		neg = ~raw + 1'b1;
		op.row  = row;
		op.col  = col;
		op.last = last;
		op.kind = norm_kind;
		op.diag = (row == col);
		op.mag  = raw[VALUE_WIDTH-1] ? 24'(neg) : 24'(raw);
		if (raw[VALUE_WIDTH-1] && neg == raw)
			op.mag = 24'(raw);
		op.take = ({1'b0, row} < eff) && ({1'b0, col} < eff) &&
			(triangle ? (row >= col) : (row <= col));
	end

	assign in_ready = (cnt_q != 2'(QD));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_op = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= op;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q  <= 1'b0;
			wp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* design/smn_sqrt.sv */
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on smn_pkg.
module smn_sqrt import smn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      x,
	output logic             done,
	output logic [SUM_W-1:0] root
);
	logic [63:0] rem_q, res_q, bit_q;
	logic        busy_q;
	logic [63:0] trial;
	logic [63:0] r;

	assign trial = res_q + bit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) busy_q <= 1'b1;
			else if (busy_q && bit_q == 64'd0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q && bit_q != 64'd0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
	assign r = res_q;
	assign root = (r > 64'(SUM_MAX)) ? SUM_MAX : r[SUM_W-1:0];
endmodule

/* design/smn_back.sv */
// Back end: row-sum memory updates, max, sum of squares, final norm.
// Depends on smn_pkg, smn_ram, smn_sqrt.
module smn_back import smn_pkg::*; #(
	parameter int MAX_ORDER = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  smn_op_t          q_op,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SUM_W-1:0] out_norm
);
	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RD    = 8'b0000_0010,
		ST_WR    = 8'b0000_0100,
		ST_RD2   = 8'b0000_1000,
		ST_WR2   = 8'b0001_0000,
		ST_CLR   = 8'b0010_0000,
		ST_SQRT  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} st_t;

	st_t              st_q;
	smn_op_t          op_q;
	logic [SUM_W-1:0] max_q, norm_q;
	logic [63:0]      sq_sum_q, sq_q;
	logic [47:0]      sq_prod;
	logic [AW-1:0]    clr_q;
	logic [AW:0]      clr_cnt;
	logic [SUM_W-1:0] rdata, sum;
	logic [SUM_W:0]   sum_w;
	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [SUM_W-1:0] wdata;
	logic [64:0]      add1;
	logic             sq_done;
	logic [SUM_W-1:0] root;
	logic [SUM_W-1:0] mag30;
	// Frobenius finish: the last square is folded in before the root starts
	logic             fin_q;

	assign mag30 = SUM_W'(op_q.mag);
	assign sum_w = {1'b0, rdata} + {1'b0, mag30};
	assign sum   = sum_w[SUM_W] ? SUM_MAX : sum_w[SUM_W-1:0];
	assign add1  = {1'b0, sq_sum_q} + {1'b0, sq_q};
	assign clr_cnt = {1'b0, clr_q} + 1'b1;
	assign sq_prod = q_op.mag * q_op.mag;

	always_comb begin
		raddr = (st_q == ST_RD2 || st_q == ST_WR) ? op_q.col[AW-1:0]
			: op_q.row[AW-1:0];
		we    = 1'b0;
		waddr = op_q.row[AW-1:0];
		wdata = sum;
		unique case (st_q)
			ST_WR:  we = 1'b1;
			ST_WR2: begin we = 1'b1; waddr = op_q.col[AW-1:0]; end
			ST_CLR: begin we = 1'b1; waddr = clr_q; wdata = '0; end
			default: ;
		endcase
	end

	smn_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ORDER)) u_rows (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	smn_sqrt u_sqrt (
		.clk, .arst_n, .start(fin_q), .x(sq_sum_q), .done(sq_done), .root
	);

	assign q_ready   = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_norm  = norm_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			op_q <= q_op;
			sq_q <= {16'd0, sq_prod};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLR;
			max_q    <= '0;
			sq_sum_q <= '0;
			clr_q    <= '0;
			norm_q   <= '0;
			fin_q    <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_RD;
				ST_RD: begin
					// state for memory read / square register
					if (op_q.take && op_q.kind == KIND_MAXABS) begin
						if (mag30 > max_q) max_q <= mag30;
						st_q <= ST_SQRT;
					end else if (op_q.take && op_q.kind == KIND_ONEINF) begin
						st_q <= ST_WR;
					end else begin
						if (op_q.take && op_q.kind == KIND_FROB) begin
							sq_sum_q <= add1[64] ? '1 : add1[63:0];
							if (!op_q.diag) st_q <= ST_RD2;
							else st_q <= ST_SQRT;
						end else st_q <= ST_SQRT;
					end
				end
				ST_WR: begin
					if (sum > max_q) max_q <= sum;
					st_q <= op_q.diag ? ST_SQRT : ST_RD2;
				end
				ST_RD2: begin
					if (op_q.kind == KIND_FROB) begin
						sq_sum_q <= add1[64] ? '1 : add1[63:0];
						st_q <= ST_SQRT;
					end else st_q <= ST_WR2;
				end
				ST_WR2: begin
					if (op_q.kind == KIND_ONEINF && sum > max_q) max_q <= sum;
					st_q <= ST_SQRT;
				end
				ST_SQRT: begin
					// decision point: finish item, or produce the norm
					if (!op_q.last) st_q <= ST_IDLE;
					else if (op_q.kind == KIND_FROB) begin
						if (!fin_q && clr_q == '0 && !sq_done) begin
							fin_q <= 1'b1;
							clr_q <= '1;
						end else if (sq_done) begin
							norm_q <= root;
							st_q   <= ST_OUT;
						end
					end else begin
						norm_q <= (op_q.kind == KIND_MAXABS ||
							op_q.kind == KIND_ONEINF) ? max_q : '0;
						st_q <= ST_OUT;
					end
				end
				ST_OUT: if (out_ready) begin
					st_q     <= ST_CLR;
					clr_q    <= '0;
					max_q    <= '0;
					sq_sum_q <= '0;
				end
				ST_CLR: begin
					clr_q <= clr_cnt[AW-1:0];
					if (clr_cnt == (AW+1)'(MAX_ORDER)) begin
						st_q  <= ST_IDLE;
						clr_q <= '0;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* design/smn_checker.sv */
// Port-level checker for the symmetric matrix norm unit, bound to the top.
// Depends on symmetric_matrix_norm_unit ports only.
module smn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00) else $error("pad bits set");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid) else $error("result repeated");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid})) else $error("handshake unknown");
endmodule

bind symmetric_matrix_norm_unit smn_checker u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
